FILE: rtl/lmfs_pkg.sv
// package: shared types and constants for the led matrix frame serializer
`default_nettype none

package lmfs_pkg;

    localparam int CHAIN_LENGTH_DEF = 4;
    localparam int ROWS_PER_DISPLAY = 8;
    localparam int ROW_W            = 3;

    typedef enum logic [2:0] {
        CMD_WRITE_ROW = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_INVERT    = 3'd2,
        CMD_REFRESH   = 3'd3,
        CMD_RAW_SEND  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INV_RD,
        ST_INV_WR,
        ST_REF_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr;
        logic clr;
        logic rd;
    } t_store_ctl;

endpackage

`default_nettype wire

FILE: rtl/lmfs_if.sv
// interfaces: command channel and word channel with valid/ready handshake
`default_nettype none

interface lmfs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [1:0] device;
    logic [2:0] row;
    logic [7:0] data;
    logic [3:0] register_addr;

    modport source (output valid, cmd, device, row, data, register_addr, input ready);
    modport sink   (input valid, cmd, device, row, data, register_addr, output ready);
endinterface

interface lmfs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic [1:0]  chain_slot;
    logic        frame_last;
    logic        item_last;

    modport source (output valid, word, chain_slot, frame_last, item_last, input ready);
    modport sink   (input valid, word, chain_slot, frame_last, item_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/lmfs_store.sv
// frame store: single-port row memory with per-entry valid bits, registered read
`default_nettype none

module lmfs_store #(
    parameter int CHAIN_LENGTH = lmfs_pkg::CHAIN_LENGTH_DEF,
    localparam int DEPTH = CHAIN_LENGTH * lmfs_pkg::ROWS_PER_DISPLAY,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lmfs_pkg::t_store_ctl  i_ctl,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic [7:0]            i_wdata,
    input  wire logic [1:0]            i_clr_dev,
    output logic [7:0]                 o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic       r_valid [DEPTH];
    logic [7:0] r_rd_data;
    logic       r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // valid bits: cleared entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_valid <= 1'b0;
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i_ctl.clr && (i / lmfs_pkg::ROWS_PER_DISPLAY) == int'(i_clr_dev)) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (i_ctl.wr) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : 8'd0;

endmodule

`default_nettype wire

FILE: rtl/lmfs_ctrl.sv
// sequencer: command decode, invert and refresh sweeps, word output register
`default_nettype none

module lmfs_ctrl #(
    parameter int CHAIN_LENGTH = lmfs_pkg::CHAIN_LENGTH_DEF,
    localparam int DEPTH = CHAIN_LENGTH * lmfs_pkg::ROWS_PER_DISPLAY,
    localparam int AW    = $clog2(DEPTH),
    localparam int SW    = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lmfs_in_if.sink                    i_in,
    lmfs_out_if.source                 o_out,
    output lmfs_pkg::t_store_ctl       o_ctl,
    output logic [AW-1:0]              o_addr,
    output logic [7:0]                 o_wdata,
    output logic [1:0]                 o_clr_dev,
    input  wire logic [7:0]            i_rdata
);

    lmfs_pkg::t_state r_state, n_state;
    lmfs_pkg::t_cmd   r_cmd, n_cmd;
    logic [1:0]                    r_dev, n_dev;
    logic [lmfs_pkg::ROW_W-1:0]    r_row, n_row;
    logic [7:0]                    r_data, n_data;
    logic [3:0]                    r_reg, n_reg;
    logic [SW-1:0]                 r_slot, n_slot;
    logic                          r_out_valid, n_out_valid;
    logic [15:0]                   r_word, n_word;
    logic [1:0]                    r_chain_slot, n_chain_slot;
    logic                          r_frame_last, n_frame_last;
    logic                          r_item_last, n_item_last;

    logic       accept;
    logic       dev_ok;
    logic       out_free;
    logic       last_row;
    logic       item_end;
    logic [7:0] reg_byte;
    logic [7:0] value;

    assign accept   = i_in.valid && i_in.ready;
    assign dev_ok   = int'(i_in.device) < CHAIN_LENGTH;
    assign out_free = !r_out_valid || o_out.ready;
    assign last_row = r_row == lmfs_pkg::ROW_W'(lmfs_pkg::ROWS_PER_DISPLAY - 1);
    assign item_end = (r_cmd == lmfs_pkg::CMD_RAW_SEND) || last_row;
    assign reg_byte = (r_cmd == lmfs_pkg::CMD_REFRESH) ?
                      {4'd0, 4'(r_row) + 4'd1} : {4'd0, r_reg};
    assign value    = (r_cmd == lmfs_pkg::CMD_REFRESH) ? i_rdata : r_data;

    assign i_in.ready       = r_state == lmfs_pkg::ST_IDLE;
    assign o_out.valid      = r_out_valid;
    assign o_out.word       = r_word;
    assign o_out.chain_slot = r_chain_slot;
    assign o_out.frame_last = r_frame_last;
    assign o_out.item_last  = r_item_last;
    assign o_clr_dev        = r_state == lmfs_pkg::ST_IDLE ? i_in.device : r_dev;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_dev        = r_dev;
        n_row        = r_row;
        n_data       = r_data;
        n_reg        = r_reg;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid;
        n_word       = r_word;
        n_chain_slot = r_chain_slot;
        n_frame_last = r_frame_last;
        n_item_last  = r_item_last;
        o_ctl        = '0;
        o_addr       = AW'({r_dev, r_row});
        o_wdata      = ~i_rdata;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lmfs_pkg::ST_IDLE: begin
                o_addr  = AW'({i_in.device, i_in.row});
                o_wdata = i_in.data;
                if (accept) begin
                    n_cmd  = lmfs_pkg::t_cmd'(i_in.cmd);
                    n_dev  = i_in.device;
                    n_data = i_in.data;
                    n_reg  = i_in.register_addr;
                    n_row  = '0;
                    n_slot = SW'(CHAIN_LENGTH - 1);
                    if (dev_ok) begin
                        case (lmfs_pkg::t_cmd'(i_in.cmd))
                            lmfs_pkg::CMD_WRITE_ROW: o_ctl.wr = 1'b1;
                            lmfs_pkg::CMD_CLEAR:     o_ctl.clr = 1'b1;
                            lmfs_pkg::CMD_INVERT:    n_state = lmfs_pkg::ST_INV_RD;
                            lmfs_pkg::CMD_REFRESH:   n_state = lmfs_pkg::ST_REF_RD;
                            lmfs_pkg::CMD_RAW_SEND:  n_state = lmfs_pkg::ST_EMIT;
                            default:                 n_state = lmfs_pkg::ST_IDLE;
                        endcase
                    end
                end
            end
            lmfs_pkg::ST_INV_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = lmfs_pkg::ST_INV_WR;
            end
            lmfs_pkg::ST_INV_WR: begin
                o_ctl.wr = 1'b1;
                n_row    = r_row + 1'b1;
                n_state  = last_row ? lmfs_pkg::ST_IDLE : lmfs_pkg::ST_INV_RD;
            end
            lmfs_pkg::ST_REF_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = lmfs_pkg::ST_EMIT;
            end
            lmfs_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_word       = (int'(r_slot) == int'(r_dev)) ? {reg_byte, value} : 16'd0;
                    n_chain_slot = 2'(r_slot);
                    n_frame_last = r_slot == '0;
                    n_item_last  = (r_slot == '0) && item_end;
                    if (r_slot == '0) begin
                        n_slot = SW'(CHAIN_LENGTH - 1);
                        n_row  = r_row + 1'b1;
                        n_state = item_end ? lmfs_pkg::ST_IDLE : lmfs_pkg::ST_REF_RD;
                    end else begin
                        n_slot = r_slot - 1'b1;
                    end
                end
            end
            default: begin
                n_state = lmfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmfs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_dev        <= n_dev;
        r_row        <= n_row;
        r_data       <= n_data;
        r_reg        <= n_reg;
        r_slot       <= n_slot;
        r_word       <= n_word;
        r_chain_slot <= n_chain_slot;
        r_frame_last <= n_frame_last;
        r_item_last  <= n_item_last;
    end

endmodule

`default_nettype wire

FILE: rtl/led_matrix_framebuffer_serializer_unit.sv
// top level: frame store serializer for a daisy chain of led matrix displays
//
// command channel i_in carries cmd, device, row, data and register_addr; a
// transfer happens when valid and ready are both high. word channel o_out
// carries word, chain_slot, frame_last and item_last from one output register.
// write row and clear take the transfer cycle only and produce no words. invert
// sweeps the eight rows of a display through the single memory port, read then
// write. a raw send emits one frame of CHAIN_LENGTH words, slot
// CHAIN_LENGTH-1 first, one word per cycle while the receiver takes them; the
// sequencer enters its emit state after the transfer and then loads the first
// word into the output register, and ready returns once the last word is
// loaded. a refresh emits eight frames; each frame first reads its row from
// the store and then emits CHAIN_LENGTH words. one command is worked on at a
// time; ready is high only between commands. commands with an unknown code or
// a device beyond the chain are dropped. reset clears the per-entry valid
// bits at once, so every row reads as zero. when the receiver stalls, the
// output word holds and the sequencer waits.
`default_nettype none

module led_matrix_framebuffer_serializer_unit #(
    parameter int CHAIN_LENGTH = lmfs_pkg::CHAIN_LENGTH_DEF,
    localparam int DEPTH = CHAIN_LENGTH * lmfs_pkg::ROWS_PER_DISPLAY,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lmfs_in_if.sink    i_in,
    lmfs_out_if.source o_out
);

    lmfs_pkg::t_store_ctl ctl;
    logic [AW-1:0]        addr;
    logic [7:0]           wdata;
    logic [1:0]           clr_dev;
    logic [7:0]           rdata;

    lmfs_ctrl #(
        .CHAIN_LENGTH(CHAIN_LENGTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_ctl    (ctl),
        .o_addr   (addr),
        .o_wdata  (wdata),
        .o_clr_dev(clr_dev),
        .i_rdata  (rdata)
    );

    lmfs_store #(
        .CHAIN_LENGTH(CHAIN_LENGTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_addr   (addr),
        .i_wdata  (wdata),
        .i_clr_dev(clr_dev),
        .o_rdata  (rdata)
    );

    // at most one memory access per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.wr, ctl.clr, ctl.rd}))
        else $error("store accessed twice in one cycle");

    // a refresh transfer blocks the command channel
    a_refresh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == lmfs_pkg::CMD_REFRESH
         && int'(i_in.device) < CHAIN_LENGTH) |=> !i_in.ready)
        else $error("command taken during refresh");

    // the last word of a command closes a frame on slot zero
    a_item_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.item_last) |-> (o_out.frame_last && o_out.chain_slot == 2'd0))
        else $error("item_last off a frame end");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// testbench for the led matrix frame serializer: directed and random commands against a row-store model
`timescale 1ns / 1ps

module tb_top;

    localparam int          CHAIN         = lmfs_pkg::CHAIN_LENGTH_DEF;
    localparam int          ROWS          = lmfs_pkg::ROWS_PER_DISPLAY;
    localparam int          RANDOM_CMDS   = 160;
    localparam int          MAX_WAIT      = 11;
    localparam int          DRAIN_CYCLES  = 8 * (CHAIN + 1) + 24;
    localparam int          LIMIT_CYCLES  = 600000;
    localparam logic [2:0]  CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0]  CMD_BAD_MID   = 3'd6;
    localparam logic [2:0]  CMD_BAD_LAST  = 3'd7;

    typedef struct {
        logic [2:0] cmd;
        logic [1:0] device;
        logic [2:0] row;
        logic [7:0] data;
        logic [3:0] register_addr;
    } t_cmd_item;

    typedef struct {
        logic [15:0] word;
        logic [1:0]  chain_slot;
        logic        frame_last;
        logic        item_last;
    } t_chain_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lmfs_in_if  cmd_if ();
    lmfs_out_if word_if ();

    led_matrix_framebuffer_serializer_unit #(
        .CHAIN_LENGTH(CHAIN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (word_if)
    );

    t_cmd_item   pending_cmds[$];
    t_chain_word expected_words[$];
    logic [7:0]  display_rows[CHAIN][ROWS];

    logic cmd_taken  = 1'b0;
    logic word_taken = 1'b0;
    int   cycle_count = 0;
    int   fail_count  = 0;
    int   cmd_gap     = 0;
    int   word_stall  = 0;
    int   cmd_phase   = 0;
    int   word_phase  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // runs of calm items alternate with random waits
    function automatic int draw_wait(ref int phase);
        phase = (phase + 1) % 40;
        return (phase < 12) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic add_cmd(logic [2:0] cmd, logic [1:0] device, logic [2:0] row,
                           logic [7:0] data, logic [3:0] register_addr);
        t_cmd_item it;
        it.cmd           = cmd;
        it.device        = device;
        it.row           = row;
        it.data          = data;
        it.register_addr = register_addr;
        pending_cmds.push_back(it);
    endtask

    task automatic push_frame(int device, logic [7:0] reg_num, logic [7:0] value,
                              logic final_frame);
        t_chain_word w;
        for (int slot = CHAIN - 1; slot >= 0; slot--) begin
            w.word       = (slot == device) ? {reg_num, value} : 16'h0000;
            w.chain_slot = 2'(slot);
            w.frame_last = (slot == 0);
            w.item_last  = (slot == 0) && final_frame;
            expected_words.push_back(w);
        end
    endtask

    task automatic apply_cmd(t_cmd_item it);
        int dev;
        dev = it.device;
        if (dev < CHAIN) begin
            case (it.cmd)
                lmfs_pkg::CMD_WRITE_ROW: display_rows[dev][it.row] = it.data;
                lmfs_pkg::CMD_CLEAR: begin
                    for (int r = 0; r < ROWS; r++) display_rows[dev][r] = 8'h00;
                end
                lmfs_pkg::CMD_INVERT: begin
                    for (int r = 0; r < ROWS; r++)
                        display_rows[dev][r] = ~display_rows[dev][r];
                end
                lmfs_pkg::CMD_REFRESH: begin
                    for (int r = 0; r < ROWS; r++)
                        push_frame(dev, 8'(r + 1), display_rows[dev][r],
                                   r == ROWS - 1);
                end
                lmfs_pkg::CMD_RAW_SEND:
                    push_frame(dev, {4'h0, it.register_addr}, it.data, 1'b1);
                default: ;
            endcase
        end
    endtask

    task automatic check_word();
        t_chain_word want;
        if (expected_words.size() == 0) begin
            $error("unexpected word %h on slot %0d", word_if.word, word_if.chain_slot);
            fail_count++;
        end else begin
            want = expected_words.pop_front();
            if (word_if.word !== want.word) begin
                $error("word: expected %h, actual %h", want.word, word_if.word);
                fail_count++;
            end
            if (word_if.chain_slot !== want.chain_slot) begin
                $error("chain_slot: expected %0d, actual %0d", want.chain_slot,
                       word_if.chain_slot);
                fail_count++;
            end
            if (word_if.frame_last !== want.frame_last) begin
                $error("frame_last: expected %b, actual %b", want.frame_last,
                       word_if.frame_last);
                fail_count++;
            end
            if (word_if.item_last !== want.item_last) begin
                $error("item_last: expected %b, actual %b", want.item_last,
                       word_if.item_last);
                fail_count++;
            end
        end
    endtask

    // sample both channels
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        cmd_taken   <= i_rst_n && cmd_if.valid && cmd_if.ready;
        word_taken  <= i_rst_n && word_if.valid && word_if.ready;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            apply_cmd('{cmd_if.cmd, cmd_if.device, cmd_if.row, cmd_if.data,
                        cmd_if.register_addr});
        end
        if (i_rst_n && word_if.valid && word_if.ready) check_word();
    end

    // command driver
    always @(negedge i_clk) begin
        t_cmd_item it;
        if (i_rst_n) begin
            if (cmd_if.valid && !cmd_taken) begin
                // transfer still pending
            end else if (cmd_gap > 0) begin
                cmd_if.valid <= 1'b0;
                cmd_gap--;
            end else if (pending_cmds.size() != 0) begin
                it = pending_cmds.pop_front();
                cmd_if.cmd           <= it.cmd;
                cmd_if.device        <= it.device;
                cmd_if.row           <= it.row;
                cmd_if.data          <= it.data;
                cmd_if.register_addr <= it.register_addr;
                cmd_if.valid         <= 1'b1;
                cmd_gap = draw_wait(cmd_phase);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // word receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (word_taken) word_stall = draw_wait(word_phase);
            if (word_stall > 0) begin
                word_if.ready <= 1'b0;
                word_stall--;
            end else begin
                word_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int useful;
        int pick;
        logic [2:0] cmd;

        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.cmd           = lmfs_pkg::CMD_WRITE_ROW;
        cmd_if.device        = 2'd0;
        cmd_if.row           = 3'd0;
        cmd_if.data          = 8'h00;
        cmd_if.register_addr = 4'h0;
        word_if.ready        = 1'b0;
        for (int d = 0; d < CHAIN; d++)
            for (int r = 0; r < ROWS; r++) display_rows[d][r] = 8'h00;

        // directed: fresh store, field extremes, every command, unknown codes
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd0, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_WRITE_ROW, 2'd3, 3'd7, 8'hFF, 4'h0);
        add_cmd(lmfs_pkg::CMD_WRITE_ROW, 2'd3, 3'd0, 8'hA5, 4'hF);
        add_cmd(lmfs_pkg::CMD_WRITE_ROW, 2'd0, 3'd7, 8'h01, 4'h0);
        add_cmd(lmfs_pkg::CMD_WRITE_ROW, 2'd1, 3'd3, 8'h80, 4'h0);
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd3, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_RAW_SEND,  2'd3, 3'd0, 8'hFF, 4'hF);
        add_cmd(lmfs_pkg::CMD_RAW_SEND,  2'd0, 3'd7, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_RAW_SEND,  2'd2, 3'd5, 8'h5A, 4'hC);
        add_cmd(lmfs_pkg::CMD_INVERT,    2'd3, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd3, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_INVERT,    2'd1, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_INVERT,    2'd1, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd1, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_CLEAR,     2'd3, 3'd7, 8'hFF, 4'hF);
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd3, 3'd0, 8'h00, 4'h0);
        add_cmd(CMD_BAD_FIRST,           2'd0, 3'd1, 8'h11, 4'h1);
        add_cmd(CMD_BAD_MID,             2'd2, 3'd2, 8'h22, 4'h2);
        add_cmd(CMD_BAD_LAST,            2'd3, 3'd7, 8'hFF, 4'hF);
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd0, 3'd0, 8'h00, 4'h0);
        add_cmd(lmfs_pkg::CMD_REFRESH,   2'd2, 3'd0, 8'h00, 4'h0);

        useful = 0;
        while (useful < RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      cmd = lmfs_pkg::CMD_WRITE_ROW;
            else if (pick < 40) cmd = lmfs_pkg::CMD_CLEAR;
            else if (pick < 50) cmd = lmfs_pkg::CMD_INVERT;
            else if (pick < 65) cmd = lmfs_pkg::CMD_REFRESH;
            else if (pick < 90) cmd = lmfs_pkg::CMD_RAW_SEND;
            else                cmd = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
            add_cmd(cmd, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            if (cmd < CMD_BAD_FIRST) useful++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lmfs_pkg.sv
rtl/lmfs_if.sv
rtl/lmfs_store.sv
rtl/lmfs_ctrl.sv
rtl/led_matrix_framebuffer_serializer_unit.sv
verif/tb_top.sv
